[rtl/decaying_bucket_histogram_unit_macros.svh]
// Assertion macros shared by the histogram RTL.
`ifndef DECAYING_BUCKET_HISTOGRAM_UNIT_MACROS_SVH
`define DECAYING_BUCKET_HISTOGRAM_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property with reset disable.
`define DBH_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked property that also holds while reset is active.
`define DBH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define DBH_ASSERT(lbl, clk, rst, prop, msg)
`define DBH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[rtl/dbh_pkg.sv]
package dbh_pkg;

   localparam int DEF_NUM_BUCKETS = 16;
   localparam int DEF_WEIGHT_BITS = 32;
   localparam int VOTE_BITS       = 16;
   localparam logic [15:0] ALPHA_RESET = 16'd66;
   localparam logic [VOTE_BITS-1:0] VOTE_MAX = '1;

   localparam logic KIND_STORE = 1'b0;
   localparam logic KIND_INFER = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_SC_RD,
      ST_SC_LO,
      ST_SC_HI,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_VOTE_RD,
      ST_VOTE_GO,
      ST_VOTE_DIV,
      ST_VOTE_OUT
   } state_type;

endpackage

[rtl/dbh_divider.sv]
module dbh_divider #(
   parameter int TW = 38
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [TW-1:0]                 dividend,
   input  logic [TW-1:0]                 divisor,
   output logic                          done,
   output logic [dbh_pkg::VOTE_BITS-1:0] quotient
);
   import dbh_pkg::*;

   localparam int CW = $clog2(VOTE_BITS + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              sat_ff, sat_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [TW-1:0]     rem_ff, rem_in;
   logic [TW-1:0]     div_ff, div_in;
   logic [VOTE_BITS-1:0] quo_ff, quo_in;
   logic [TW:0]       shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, 1'b0};
      if (start) begin
         // The dividend never exceeds the divisor, so only equality overflows.
         sat_in  = (dividend >= divisor);
         rem_in  = (dividend >= divisor) ? '0 : dividend;
         div_in  = divisor;
         quo_in  = '0;
         cnt_in  = CW'(VOTE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = TW'(shifted - {1'b0, div_ff});
            quo_in = {quo_ff[VOTE_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[TW-1:0];
            quo_in = {quo_ff[VOTE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? VOTE_MAX : quo_ff;

`include "decaying_bucket_histogram_unit_macros.svh"
   `DBH_ASSERT(a_no_restart, clock, reset, start |-> !busy_ff, "divider restarted while busy")
   `DBH_ASSERT(a_done_pulse, clock, reset, done_ff |=> !done_ff, "divider done held")
   `DBH_ASSERT(a_done_idle, clock, reset, done_ff |-> !busy_ff, "divider done while busy")

endmodule

[rtl/decaying_bucket_histogram_unit.sv]
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tuser kind, tdata iteration and bucket
// rsp      out  rsp_tvalid/tready     tdata vote_bucket and vote, tlast
// csr      in   csr_wr_en             alpha
// A store runs the power steps (skipped when alpha is zero), then a scale pass
// over every bucket, all on one shared 32x32 multiplier.
// An infer sums every bucket for the total, then forms each vote on the serial
// divider (skipped when the total is zero), and waits out any rsp stalls.
// Reset is synchronous; weights read as zero until first written.
// req_tready is high only while no item is in work.
module decaying_bucket_histogram_unit #(
   parameter int NUM_BUCKETS = dbh_pkg::DEF_NUM_BUCKETS,
   parameter int WEIGHT_BITS = dbh_pkg::DEF_WEIGHT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // iteration[31:0], bucket[35:32], zero fill
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // vote_bucket[3:0], vote[19:4], zero fill
   output logic        rsp_tlast,   // last
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data  // alpha
);
   import dbh_pkg::*;

   localparam int WB   = WEIGHT_BITS;
   localparam int WX   = WB + 1;
   localparam int IDXW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int TW   = WB + IDXW;
   localparam int VC   = (NUM_BUCKETS < 16) ? NUM_BUCKETS : 16;

   state_type state_ff, state_in;

   logic [15:0]     alpha_ff;
   logic            started_ff, started_in;
   logic [31:0]     last_iter_ff, last_iter_in;
   logic [31:0]     elapsed_ff, elapsed_in;
   logic            hit_ff, hit_in;
   logic [3:0]      bucket_ff, bucket_in;
   logic [4:0]      step_ff, step_in;
   logic [31:0]     base_ff, base_in;
   logic [31:0]     acc_ff, acc_in;
   logic            acc_one_ff, acc_one_in;
   logic [IDXW-1:0] idx_ff, idx_in;
   logic [31:0]     part_ff, part_in;
   logic [WB-1:0]   wcur_ff, wcur_in;
   logic [TW-1:0]   total_ff, total_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_vote_ff, rsp_vote_in;
   logic [3:0]      rsp_bucket_ff, rsp_bucket_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [WB-1:0]   mem [NUM_BUCKETS];
   logic            valid_ff [NUM_BUCKETS];
   logic [WB-1:0]   rd_data_ff;
   logic            rd_vld_ff;
   logic            wr_en;
   logic [WB-1:0]   wr_data;

   logic [31:0]     mul_a, mul_b;
   logic [63:0]     mul_p;
   logic [WB-1:0]   rd_word;
   logic [63:0]     rd_ext, scaled;
   logic [WB-1:0]   decayed;
   logic [WX-1:0]   add_sum;
   logic [31:0]     req_iter;
   logic [3:0]      req_bucket;
   logic            div_start, div_done;
   logic [15:0]     div_quo;
   logic            last_bucket, last_vote;

   assign req_iter    = req_tdata[31:0];
   assign req_bucket  = req_tdata[35:32];
   assign rd_word     = rd_vld_ff ? rd_data_ff : '0;
   assign rd_ext      = 64'(rd_word);
   assign mul_p       = 64'(mul_a) * 64'(mul_b);
   assign last_bucket = (idx_ff == IDXW'(NUM_BUCKETS - 1));
   assign last_vote   = (idx_ff == IDXW'(VC - 1));

   always_comb begin
      unique case (state_ff)
         ST_POW_MUL: begin mul_a = acc_ff;            mul_b = base_ff; end
         ST_POW_SQR: begin mul_a = base_ff;           mul_b = base_ff; end
         ST_SC_LO:   begin mul_a = rd_ext[31:0];      mul_b = acc_ff;  end
         ST_SC_HI:   begin mul_a = 32'(wcur_ff >> 32); mul_b = acc_ff; end
         default:    begin mul_a = '0;                mul_b = '0;      end
      endcase
   end

   assign scaled  = mul_p + 64'(part_ff);
   assign decayed = acc_one_ff ? wcur_ff : scaled[WB-1:0];
   assign add_sum = WX'(decayed) + (hit_ff && (7'(idx_ff) == 7'(bucket_ff)) ?
                    (WX'(alpha_ff) << (WB - 16)) : WX'(0));

   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      last_iter_in  = last_iter_ff;
      elapsed_in    = elapsed_ff;
      hit_in        = hit_ff;
      bucket_in     = bucket_ff;
      step_in       = step_ff;
      base_in       = base_ff;
      acc_in        = acc_ff;
      acc_one_in    = acc_one_ff;
      idx_in        = idx_ff;
      part_in       = part_ff;
      wcur_in       = wcur_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vote_in   = rsp_vote_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_data       = add_sum[WB] ? '1 : add_sum[WB-1:0];
      div_start     = 1'b0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            idx_in     = '0;
            if (req_tvalid) begin
               if (req_tuser == KIND_STORE) begin
                  elapsed_in = '0;
                  if (!started_ff) begin
                     started_in   = 1'b1;
                     last_iter_in = req_iter;
                  end else if (req_iter >= last_iter_ff) begin
                     elapsed_in   = req_iter - last_iter_ff;
                     last_iter_in = req_iter;
                  end
                  hit_in     = (7'(req_bucket) < 7'(NUM_BUCKETS));
                  bucket_in  = req_bucket;
                  base_in    = 32'(33'h1_0000_0000 - {1'b0, alpha_ff, 16'h0});
                  acc_one_in = 1'b1;
                  acc_in     = '0;
                  step_in    = '0;
                  // With alpha zero the factor is exactly one.
                  state_in   = (alpha_ff == '0) ? ST_SC_RD : ST_POW_MUL;
               end else begin
                  total_in = '0;
                  state_in = ST_SUM_RD;
               end
            end
         end
         ST_POW_MUL: begin
            if (elapsed_ff[step_ff]) begin
               if (acc_one_ff) begin
                  acc_in     = base_ff;
                  acc_one_in = 1'b0;
               end else begin
                  acc_in = mul_p[63:32];
               end
            end
            state_in = ST_POW_SQR;
         end
         ST_POW_SQR: begin
            base_in  = mul_p[63:32];
            step_in  = step_ff + 1'b1;
            state_in = (step_ff == 5'd31) ? ST_SC_RD : ST_POW_MUL;
         end
         ST_SC_RD: begin
            state_in = ST_SC_LO;
         end
         ST_SC_LO: begin
            part_in  = mul_p[63:32];
            wcur_in  = rd_word;
            state_in = ST_SC_HI;
         end
         ST_SC_HI: begin
            wr_en = 1'b1;
            if (last_bucket) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SC_RD;
            end
         end
         ST_SUM_RD: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            total_in = total_ff + TW'(rd_word);
            if (last_bucket) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
            state_in = last_bucket ? ST_VOTE_RD : ST_SUM_RD;
         end
         ST_VOTE_RD: begin
            state_in = ST_VOTE_GO;
         end
         ST_VOTE_GO: begin
            rsp_bucket_in = 4'(idx_ff);
            rsp_last_in   = last_vote;
            if (total_ff == '0) begin
               rsp_vote_in  = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_VOTE_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_VOTE_DIV;
            end
         end
         ST_VOTE_DIV: begin
            if (div_done) begin
               rsp_vote_in  = div_quo;
               rsp_valid_in = 1'b1;
               state_in     = ST_VOTE_OUT;
            end
         end
         ST_VOTE_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (last_vote) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_VOTE_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alpha_ff     <= ALPHA_RESET;
         started_ff   <= 1'b0;
         last_iter_ff <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         last_iter_ff <= last_iter_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         if (csr_wr_en) begin
            alpha_ff <= csr_wr_data;
         end
      end
      elapsed_ff    <= elapsed_in;
      hit_ff        <= hit_in;
      bucket_ff     <= bucket_in;
      step_ff       <= step_in;
      base_ff       <= base_in;
      acc_ff        <= acc_in;
      acc_one_ff    <= acc_one_in;
      part_ff       <= part_in;
      wcur_ff       <= wcur_in;
      total_ff      <= total_in;
      rsp_vote_ff   <= rsp_vote_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Weight store with one valid bit per entry; unwritten entries read as zero.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[idx_ff] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[idx_ff];
      end
   end

   dbh_divider #(
      .TW(TW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (TW'(rd_word)),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_vote_ff, rsp_bucket_ff};
   assign rsp_tlast  = rsp_last_ff;

`include "decaying_bucket_histogram_unit_macros.svh"
   `DBH_ASSERT(a_no_accept_busy, clock, reset, rsp_tvalid |-> !req_tready,
      "input accepted while a vote is pending")
   `DBH_ASSERT(a_last_bucket, clock, reset,
      (rsp_tvalid && rsp_tlast) |-> (rsp_bucket_ff == 4'(VC - 1)),
      "last marker on wrong bucket")
   `DBH_ASSERT(a_store_busy, clock, reset, (req_tvalid && req_tready) |=> !req_tready,
      "ready stayed high after a transfer")
   `DBH_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (!rsp_tvalid),
      "vote pending right after reset")

endmodule

[sim/testbench.sv]
module testbench;
   import dbh_pkg::*;

   localparam int NB = 16;
   localparam int RANDOM_ITEMS = 500;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [3:0]  vote_bucket;
      logic [15:0] vote;
      logic        last;
   } vote_t;

   typedef struct packed {
      logic        kind;
      logic [31:0] iteration;
      logic [3:0]  bucket;
      logic        check;
      logic [15:0] want_vote0;
      logic [15:0] cfg;
   } row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;

   decaying_bucket_histogram_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // Predicted histogram state.
   logic [31:0] hist_weight [NB];
   logic [31:0] hist_last_iter;
   logic        hist_started;
   logic [15:0] hist_alpha;

   vote_t pending_votes[$];
   int    errors = 0;
   int    votes_seen = 0;
   int    stores_sent = 0;
   int    infers_sent = 0;
   int    idle_cycles = 0;
   bit    calm = 1'b0;
   int    rsp_stall = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] decay_factor(input logic [31:0] elapsed);
      logic [63:0] base;
      logic [63:0] acc;
      acc = 64'h1_0000_0000;
      if (hist_alpha == 16'd0) return acc;
      base = 64'h1_0000_0000 - ({48'd0, hist_alpha} << 16);
      for (int i = 0; i < 32; i++) begin
         if (elapsed[i]) acc = (acc * base) >> 32;
         base = (base * base) >> 32;
      end
      return acc;
   endfunction

   task automatic predict_item(input logic kind, input logic [31:0] iter,
                               input logic [3:0] bkt);
      logic [31:0] elapsed;
      logic [63:0] f;
      logic [63:0] total;
      logic [63:0] v;
      logic [32:0] sum;
      vote_t       e;
      elapsed = '0;
      if (kind == KIND_STORE) begin
         if (!hist_started) begin
            hist_started = 1'b1;
            hist_last_iter = iter;
         end else if (iter >= hist_last_iter) begin
            elapsed = iter - hist_last_iter;
            hist_last_iter = iter;
         end
         f = decay_factor(elapsed);
         for (int i = 0; i < NB; i++)
            hist_weight[i] = 32'(({32'd0, hist_weight[i]} * f) >> 32);
         sum = {1'b0, hist_weight[bkt]} + {1'b0, hist_alpha, 16'd0};
         hist_weight[bkt] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end else begin
         total = '0;
         for (int i = 0; i < NB; i++) total += hist_weight[i];
         for (int i = 0; i < NB; i++) begin
            v = 0;
            if (total != 0) begin
               v = ({32'd0, hist_weight[i]} << 16) / total;
               if (v > 64'hFFFF) v = 64'hFFFF;
            end
            e.vote_bucket = 4'(i);
            e.vote = v[15:0];
            e.last = (i == NB - 1);
            pending_votes.push_back(e);
         end
      end
   endtask

   // Sends one item, idling first when allowed. Valid stays high after the
   // transfer so that the next item can follow at once; callers drop it.
   task automatic send_item(input logic kind, input logic [31:0] iter,
                            input logic [3:0] bkt);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'd0, bkt, iter};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(kind, iter, bkt);
      if (kind == KIND_STORE) stores_sent++;
      else infers_sent++;
   endtask

   // Waits for all votes plus the length of a full store before a write.
   task automatic write_alpha(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (pending_votes.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      hist_alpha = value;
   endtask

   // Result side: stall bursts and checking.
   always @(posedge clock) begin
      vote_t got;
      vote_t want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.vote_bucket = rsp_tdata[3:0];
            got.vote = rsp_tdata[19:4];
            got.last = rsp_tlast;
            votes_seen++;
            if (pending_votes.size() == 0) begin
               $display("%0t: unexpected vote %h", $time, got);
               errors++;
            end else begin
               want = pending_votes.pop_front();
               if (got !== want) begin
                  $display("%0t: expected bkt %0d vote %h last %b, actual bkt %0d vote %h last %b",
                           $time, want.vote_bucket, want.vote, want.last,
                           got.vote_bucket, got.vote, got.last);
                  errors++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(1, 6) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("FAIL decaying_bucket_histogram_unit");
         $finish;
      end
   end

   row_t directed [] = '{
      // The first store only sets the time base; after one store all weight is in bucket 3.
      '{KIND_INFER, 32'd0, 4'd0, 1'b1, 16'd0, 16'd0},
      '{KIND_STORE, 32'd1000, 4'd3, 1'b0, 16'd0, 16'd0},
      '{KIND_INFER, 32'd0, 4'd0, 1'b1, 16'd0, 16'd0},
      '{KIND_STORE, 32'd999, 4'd0, 1'b0, 16'd0, 16'd0},
      '{KIND_STORE, 32'd1001, 4'd15, 1'b0, 16'd0, 16'd0},
      '{KIND_STORE, 32'd1001, 4'd15, 1'b0, 16'd0, 16'd0},
      '{KIND_INFER, 32'hFFFF_FFFF, 4'hF, 1'b0, 16'd0, 16'd0},
      '{KIND_STORE, 32'hFFFF_FFFF, 4'd7, 1'b0, 16'd0, 16'd0},
      '{KIND_STORE, 32'h0, 4'd8, 1'b0, 16'd0, 16'd0},
      '{KIND_INFER, 32'd0, 4'd0, 1'b0, 16'd0, 16'd0},
      // Largest alpha saturates quickly; equal iterations leave the weights undecayed.
      '{KIND_STORE, 32'hFFFF_FFFF, 4'd1, 1'b0, 16'd0, 16'hFFFF},
      '{KIND_STORE, 32'hFFFF_FFFF, 4'd1, 1'b0, 16'd0, 16'd0},
      '{KIND_STORE, 32'hFFFF_FFFF, 4'd2, 1'b0, 16'd0, 16'd0},
      '{KIND_INFER, 32'd0, 4'd0, 1'b0, 16'd0, 16'd0},
      // Smallest alpha.
      '{KIND_STORE, 32'hFFFF_FFFF, 4'd5, 1'b0, 16'd0, 16'd1},
      '{KIND_STORE, 32'hFFFF_FFFF, 4'd5, 1'b0, 16'd0, 16'd0},
      '{KIND_INFER, 32'd0, 4'd0, 1'b0, 16'd0, 16'd0}
   };

   initial begin
      logic [31:0] iter;
      logic        kind;
      for (int i = 0; i < NB; i++) hist_weight[i] = '0;
      hist_last_iter = '0;
      hist_started = 1'b0;
      hist_alpha = ALPHA_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[r]) begin
         if (directed[r].cfg != 16'd0) write_alpha(directed[r].cfg);
         send_item(directed[r].kind, directed[r].iteration, directed[r].bucket);
         if (directed[r].check && pending_votes.size() != 0) begin
            // Votes after reset are zero; after one store bucket 3 holds everything.
            if (r == 0 && pending_votes[0].vote !== directed[r].want_vote0) begin
               $display("%0t: table row %0d expected vote %h, predicted %h",
                        $time, r, directed[r].want_vote0, pending_votes[0].vote);
               errors++;
            end
            if (r == 2 && pending_votes[3].vote !== VOTE_MAX) begin
               $display("%0t: table row %0d expected vote %h, predicted %h",
                        $time, r, VOTE_MAX, pending_votes[3].vote);
               errors++;
            end
         end
      end

      iter = hist_last_iter;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 50) begin
            case ($urandom_range(0, 3))
               0: write_alpha(16'hFFFF);
               1: write_alpha(16'd1);
               default: write_alpha(16'($urandom_range(1, 65535)));
            endcase
         end
         calm = (n > RANDOM_ITEMS - 60);
         kind = ($urandom_range(0, 4) == 0) ? KIND_INFER : KIND_STORE;
         case ($urandom_range(0, 9))
            0: iter = $urandom;
            1: iter = iter - $urandom_range(1, 5);
            default: iter = iter + $urandom_range(0, 40);
         endcase
         send_item(kind, (kind == KIND_INFER && $urandom_range(0, 1)) ? $urandom : iter,
                   4'($urandom_range(0, 15)));
         if (kind == KIND_STORE && $urandom_range(0, 1)) iter = hist_last_iter;
      end
      send_item(KIND_INFER, 32'd0, 4'd0);
      req_tvalid <= 1'b0;

      while (pending_votes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d stores and %0d infers, %0d votes checked.",
               stores_sent, infers_sent, votes_seen);
      if (errors == 0 && pending_votes.size() == 0)
         $display("PASS decaying_bucket_histogram_unit");
      else
         $display("FAIL decaying_bucket_histogram_unit");
      $finish;
   end
endmodule
